// ===== rtl/fcs_pkg.sv =====
// Shared types, codes and constants of the flash command sequencer.
package fcs_pkg;

  // Command opcodes
  localparam logic [2:0] OP_ERASE   = 3'd0;
  localparam logic [2:0] OP_PROGRAM = 3'd1;
  localparam logic [2:0] OP_READ_ID = 3'd2;
  localparam logic [2:0] OP_DATA    = 3'd3;
  localparam logic [2:0] OP_END     = 3'd4;

  // Result kinds
  localparam logic [1:0] BK_WRITE = 2'd0;
  localparam logic [1:0] BK_READ  = 2'd1;
  localparam logic [1:0] BK_DONE  = 2'd2;

  // Done status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ERASE_ERR = 2'd1;
  localparam logic [1:0] ST_PROG_TMO  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_ERASE_LIMIT = 3'd0;
  localparam logic [2:0] CFG_PROG_LIMIT  = 3'd1;
  localparam logic [2:0] CFG_ID_MAKER    = 3'd2;
  localparam logic [2:0] CFG_ID_DEVICE   = 3'd3;
  localparam logic [2:0] CFG_ARRAY_WORD  = 3'd4;

  // Configuration reset values
  localparam logic [24:0] RST_ERASE_LIMIT = 25'h1280000;
  localparam logic [15:0] RST_PROG_LIMIT  = 16'h1000;
  localparam logic [23:0] RST_ID_MAKER    = 24'h000000;
  localparam logic [23:0] RST_ID_DEVICE   = 24'h000002;
  localparam logic [15:0] RST_ARRAY_WORD  = 16'hF0F0;

  // Flash bus command set
  localparam logic [23:0] UNLOCK_ADDR1     = 24'h000AAA;
  localparam logic [23:0] UNLOCK_ADDR2     = 24'h000554;
  localparam logic [15:0] UNLOCK_DATA1     = 16'hAAAA;
  localparam logic [15:0] UNLOCK_DATA2     = 16'h5555;
  localparam logic [15:0] CMD_ERASE_SETUP  = 16'h8080;
  localparam logic [15:0] CMD_SECTOR_ERASE = 16'h3030;
  localparam logic [15:0] CMD_PROGRAM      = 16'hA0A0;
  localparam logic [15:0] CMD_AUTOSELECT   = 16'h9090;
  localparam logic [15:0] CMD_RESET        = 16'hF0F0;
  localparam int          TOGGLE_BIT       = 6;
  localparam int          TIMEOUT_BIT      = 5;

  // Job kinds handed from front to back
  localparam logic [2:0] JOB_ERASE    = 3'd0;
  localparam logic [2:0] JOB_PROGRAM  = 3'd1;
  localparam logic [2:0] JOB_ID_START = 3'd2;
  localparam logic [2:0] JOB_READ     = 3'd3;
  localparam logic [2:0] JOB_FINISH   = 3'd4;
  localparam logic [2:0] JOB_DONE     = 3'd5;
  localparam logic [2:0] JOB_ID_END   = 3'd6;

  // Job queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] addr;
    logic [15:0] word;
    logic [1:0]  status;
    logic [31:0] id;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/fcs_if.sv =====
// Handshake channel interfaces: commands, bus results and configuration writes.
interface fcs_cmd_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [23:0] target_address;
  logic [15:0] write_word;
  logic        dry_run;
  logic [15:0] returned_word;

  modport source (input clk, input ready,
                  output valid, opcode, target_address, write_word, dry_run, returned_word);
  modport sink   (input clk, input valid, opcode, target_address, write_word, dry_run,
                  returned_word, output ready);
endinterface

interface fcs_res_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  bus_kind;
  logic [23:0] bus_address;
  logic [15:0] bus_word;
  logic [1:0]  result_status;
  logic [31:0] chip_id;
  logic        last_of_run;

  modport source (input clk, input ready,
                  output valid, bus_kind, bus_address, bus_word, result_status, chip_id,
                  last_of_run);
  modport sink   (input clk, input valid, bus_kind, bus_address, bus_word, result_status,
                  chip_id, last_of_run, output ready);
endinterface

interface fcs_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [24:0] data;

  modport source (input clk, input ready, output valid, index, data);
  modport sink   (input clk, input valid, index, data, output ready);
endinterface

// ===== rtl/flash_command_sequencer.sv =====
// Top level of the flash command sequencer: front end, job queue and bus back end.
//
//   channel  role   transaction carries
//   -------  -----  ------------------------------------------------------------
//   cmd      sink   opcode, target_address, write_word, dry_run, returned_word
//   bus      source bus_kind, bus_address, bus_word, result_status, chip_id,
//                   last_of_run
//   cfg      sink   index, data (register write, always ready)
//
// A command is classified in the cycle it is accepted; cmd stays ready while the
// four-entry job queue has room, so commands may arrive every cycle.
// The back end sets the rate: one result per cycle while bus is ready. An erase gives
// seven items, program five, read id four then two, finish three and poll read one.
// A stall on bus holds the output register; the queue absorbs new commands meanwhile.
// Reset (rst, synchronous) restores register defaults and idles both ends.
module flash_command_sequencer (
  input  logic      clk,
  input  logic      rst,
  fcs_cmd_if.sink   cmd,
  fcs_res_if.source bus,
  fcs_cfg_if.sink   cfg
);

  fcs_pkg::q_ctrl_t qctrl;
  fcs_pkg::q_stat_t qstat;
  fcs_pkg::job_t    push_job;
  fcs_pkg::job_t    head_job;
  logic             push;
  logic             pop;

  assign qctrl.push = push;
  assign qctrl.pop  = pop;

  // Classify commands and advance the sequencer state
  fcs_front u_front (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .cfg   (cfg),
    .qstat (qstat),
    .push  (push),
    .job   (push_job)
  );

  // Hold pending jobs so either end can stall alone
  fcs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (qctrl),
    .wr_job (push_job),
    .rd_job (head_job),
    .stat   (qstat)
  );

  // Expand the head job into bus transactions
  fcs_back u_back (
    .clk   (clk),
    .rst   (rst),
    .job   (head_job),
    .qstat (qstat),
    .pop   (pop),
    .bus   (bus)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("job pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("job popped from empty queue");

  // A push without a pop leaves a job waiting
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> !qstat.empty)
    else $error("pushed job lost");

  // Every done item closes its run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (bus.valid && bus.bus_kind == fcs_pkg::BK_DONE) |-> bus.last_of_run)
    else $error("done item not marked last");

endmodule

// ===== rtl/fcs_queue.sv =====
// Short job queue between the command front end and the bus back end.
module fcs_queue (
  input  logic           clk,
  input  logic           rst,
  input  fcs_pkg::q_ctrl_t ctrl,
  input  fcs_pkg::job_t  wr_job,
  output fcs_pkg::job_t  rd_job,
  output fcs_pkg::q_stat_t stat
);

  fcs_pkg::job_t entries [fcs_pkg::QUEUE_DEPTH];
  logic [fcs_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [fcs_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [fcs_pkg::QUEUE_CNT_W-1:0] count;

  localparam logic [fcs_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
    fcs_pkg::QUEUE_CNT_W'(fcs_pkg::QUEUE_DEPTH);
  localparam logic [fcs_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    fcs_pkg::QUEUE_PTR_W'(fcs_pkg::QUEUE_DEPTH - 1);

  assign stat.full  = (count == FULL_COUNT);
  assign stat.empty = (count == '0);
  assign rd_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (ctrl.pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({ctrl.push, ctrl.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/fcs_front.sv =====
// Command front end: holds configuration and sequencer state, turns each command into a job.
module fcs_front (
  input  logic             clk,
  input  logic             rst,
  fcs_cmd_if.sink          cmd,
  fcs_cfg_if.sink          cfg,
  input  fcs_pkg::q_stat_t qstat,
  output logic             push,
  output fcs_pkg::job_t    job
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_ER1   = 4'd1;
  localparam logic [3:0] PH_ER2   = 4'd2;
  localparam logic [3:0] PH_ER3   = 4'd3;
  localparam logic [3:0] PH_EC1   = 4'd4;
  localparam logic [3:0] PH_EC2   = 4'd5;
  localparam logic [3:0] PH_PPOLL = 4'd6;
  localparam logic [3:0] PH_ID1   = 4'd7;
  localparam logic [3:0] PH_ID2   = 4'd8;

  logic [24:0] erase_poll_limit;
  logic [15:0] program_poll_limit;
  logic [23:0] id_maker_address;
  logic [23:0] id_device_address;
  logic [15:0] array_mode_word;

  logic [3:0]  phase, phase_next;
  logic [23:0] saved_address, saved_address_next;
  logic [15:0] expected_word, expected_word_next;
  logic [24:0] poll_count, poll_count_next;
  logic        first_toggle_sample, first_toggle_sample_next;
  logic [15:0] maker_code, maker_code_next;
  logic        session_open, session_open_next;
  logic        session_wet, session_wet_next;
  logic [23:0] session_start, session_start_next;

  logic        accept;
  logic        bit6;
  logic [24:0] poll_inc;
  logic [24:0] erase_lim;
  logic [24:0] prog_lim;

  assign cmd.ready = !qstat.full;
  assign cfg.ready = 1'b1;
  assign accept    = cmd.valid && cmd.ready;
  assign bit6      = cmd.returned_word[fcs_pkg::TOGGLE_BIT];
  assign poll_inc  = poll_count + 25'd1;
  assign erase_lim = (erase_poll_limit == '0) ? 25'd1 : erase_poll_limit;
  assign prog_lim  = (program_poll_limit == '0) ? 25'd1 : {9'd0, program_poll_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      erase_poll_limit   <= fcs_pkg::RST_ERASE_LIMIT;
      program_poll_limit <= fcs_pkg::RST_PROG_LIMIT;
      id_maker_address   <= fcs_pkg::RST_ID_MAKER;
      id_device_address  <= fcs_pkg::RST_ID_DEVICE;
      array_mode_word    <= fcs_pkg::RST_ARRAY_WORD;
    end else if (cfg.valid) begin
      case (cfg.index)
        fcs_pkg::CFG_ERASE_LIMIT: erase_poll_limit   <= cfg.data;
        fcs_pkg::CFG_PROG_LIMIT:  program_poll_limit <= cfg.data[15:0];
        fcs_pkg::CFG_ID_MAKER:    id_maker_address   <= cfg.data[23:0];
        fcs_pkg::CFG_ID_DEVICE:   id_device_address  <= cfg.data[23:0];
        fcs_pkg::CFG_ARRAY_WORD:  array_mode_word    <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next               = phase;
    saved_address_next       = saved_address;
    expected_word_next       = expected_word;
    poll_count_next          = poll_count;
    first_toggle_sample_next = first_toggle_sample;
    maker_code_next          = maker_code;
    session_open_next        = session_open;
    session_wet_next         = session_wet;
    session_start_next       = session_start;
    push                     = 1'b0;
    job.kind                 = fcs_pkg::JOB_READ;
    job.addr                 = saved_address;
    job.word                 = '0;
    job.status               = fcs_pkg::ST_OK;
    job.id                   = '0;

    if (accept) begin
      if (cmd.opcode == fcs_pkg::OP_DATA) begin
        case (phase)
          PH_ER1: begin
            first_toggle_sample_next = bit6;
            push       = 1'b1;
            phase_next = PH_ER2;
          end
          PH_ER2: begin
            push = 1'b1;
            if (bit6 == first_toggle_sample) begin
              job.kind   = fcs_pkg::JOB_FINISH;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_ER3;
            end
          end
          PH_ER3: begin
            push = 1'b1;
            if (cmd.returned_word[fcs_pkg::TIMEOUT_BIT]) begin
              phase_next = PH_EC1;
            end else begin
              poll_count_next = poll_inc;
              if (poll_inc >= erase_lim) begin
                // limit reached: report success and reset the part
                job.kind   = fcs_pkg::JOB_FINISH;
                phase_next = PH_IDLE;
              end else begin
                phase_next = PH_ER1;
              end
            end
          end
          PH_EC1: begin
            first_toggle_sample_next = bit6;
            push       = 1'b1;
            phase_next = PH_EC2;
          end
          PH_EC2: begin
            push       = 1'b1;
            job.kind   = fcs_pkg::JOB_FINISH;
            job.status = (bit6 != first_toggle_sample) ? fcs_pkg::ST_ERASE_ERR
                                                       : fcs_pkg::ST_OK;
            phase_next = PH_IDLE;
          end
          PH_PPOLL: begin
            push = 1'b1;
            if (cmd.returned_word == expected_word) begin
              job.kind   = fcs_pkg::JOB_DONE;
              phase_next = PH_IDLE;
            end else begin
              poll_count_next = poll_inc;
              if (poll_inc >= prog_lim) begin
                job.kind          = fcs_pkg::JOB_FINISH;
                job.status        = fcs_pkg::ST_PROG_TMO;
                phase_next        = PH_IDLE;
                session_open_next = 1'b0;
                session_wet_next  = 1'b0;
              end
            end
          end
          PH_ID1: begin
            maker_code_next = cmd.returned_word;
            push            = 1'b1;
            job.addr        = id_device_address;
            phase_next      = PH_ID2;
          end
          PH_ID2: begin
            push       = 1'b1;
            job.kind   = fcs_pkg::JOB_ID_END;
            job.addr   = '0;
            job.word   = array_mode_word;
            job.id     = {maker_code, cmd.returned_word};
            phase_next = PH_IDLE;
          end
          default: ;
        endcase
      end else if (phase == PH_IDLE) begin
        case (cmd.opcode)
          fcs_pkg::OP_ERASE: begin
            saved_address_next = cmd.target_address;
            poll_count_next    = '0;
            push               = 1'b1;
            job.kind           = fcs_pkg::JOB_ERASE;
            job.addr           = cmd.target_address;
            phase_next         = PH_ER1;
          end
          fcs_pkg::OP_PROGRAM: begin
            if (!session_open) begin
              session_open_next  = 1'b1;
              session_wet_next   = 1'b0;
              session_start_next = cmd.target_address;
            end
            saved_address_next = cmd.target_address;
            expected_word_next = cmd.write_word;
            poll_count_next    = '0;
            push               = 1'b1;
            if (cmd.dry_run) begin
              job.kind = fcs_pkg::JOB_DONE;
            end else begin
              session_wet_next = 1'b1;
              job.kind         = fcs_pkg::JOB_PROGRAM;
              job.addr         = cmd.target_address;
              job.word         = cmd.write_word;
              phase_next       = PH_PPOLL;
            end
          end
          fcs_pkg::OP_READ_ID: begin
            push       = 1'b1;
            job.kind   = fcs_pkg::JOB_ID_START;
            job.addr   = id_maker_address;
            phase_next = PH_ID1;
          end
          fcs_pkg::OP_END: begin
            push     = 1'b1;
            job.addr = session_start;
            job.kind = (session_open && session_wet) ? fcs_pkg::JOB_FINISH
                                                     : fcs_pkg::JOB_DONE;
            session_open_next = 1'b0;
            session_wet_next  = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      saved_address       <= '0;
      expected_word       <= '0;
      poll_count          <= '0;
      first_toggle_sample <= 1'b0;
      maker_code          <= '0;
      session_open        <= 1'b0;
      session_wet         <= 1'b0;
      session_start       <= '0;
    end else begin
      phase               <= phase_next;
      saved_address       <= saved_address_next;
      expected_word       <= expected_word_next;
      poll_count          <= poll_count_next;
      first_toggle_sample <= first_toggle_sample_next;
      maker_code          <= maker_code_next;
      session_open        <= session_open_next;
      session_wet         <= session_wet_next;
      session_start       <= session_start_next;
    end
  end

endmodule

// ===== rtl/fcs_back.sv =====
// Bus back end: expands queued jobs into bus writes, reads and done items, one per cycle while bus is ready.
module fcs_back (
  input  logic             clk,
  input  logic             rst,
  input  fcs_pkg::job_t    job,
  input  fcs_pkg::q_stat_t qstat,
  output logic             pop,
  fcs_res_if.source        bus
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] addr;
    logic [15:0] word;
    logic [1:0]  status;
    logic [31:0] id;
    logic        last;
  } item_t;

  function automatic item_t item_of(input fcs_pkg::job_t j, input logic [2:0] pos);
    item_t it;
    logic [15:0] cmd_word;
    it.kind   = fcs_pkg::BK_WRITE;
    it.addr   = '0;
    it.word   = '0;
    it.status = fcs_pkg::ST_OK;
    it.id     = '0;
    it.last   = 1'b0;
    case (j.kind)
      fcs_pkg::JOB_PROGRAM:  cmd_word = fcs_pkg::CMD_PROGRAM;
      fcs_pkg::JOB_ID_START: cmd_word = fcs_pkg::CMD_AUTOSELECT;
      default:               cmd_word = fcs_pkg::CMD_ERASE_SETUP;
    endcase
    case (j.kind)
      fcs_pkg::JOB_ERASE, fcs_pkg::JOB_PROGRAM, fcs_pkg::JOB_ID_START: begin
        case (pos)
          3'd0, 3'd3: begin
            it.addr = fcs_pkg::UNLOCK_ADDR1;
            it.word = fcs_pkg::UNLOCK_DATA1;
          end
          3'd1, 3'd4: begin
            it.addr = fcs_pkg::UNLOCK_ADDR2;
            it.word = fcs_pkg::UNLOCK_DATA2;
          end
          3'd2: begin
            it.addr = fcs_pkg::UNLOCK_ADDR1;
            it.word = cmd_word;
          end
          default: begin
            it.addr = j.addr;
            it.word = fcs_pkg::CMD_SECTOR_ERASE;
          end
        endcase
        // the tail of each command sequence
        if (j.kind == fcs_pkg::JOB_ID_START && pos == 3'd3) begin
          it.kind = fcs_pkg::BK_READ;
          it.addr = j.addr;
          it.word = '0;
          it.last = 1'b1;
        end
        if (j.kind == fcs_pkg::JOB_PROGRAM && pos == 3'd3) begin
          it.addr = j.addr;
          it.word = j.word;
        end
        if ((j.kind == fcs_pkg::JOB_PROGRAM && pos == 3'd4) ||
            (j.kind == fcs_pkg::JOB_ERASE && pos == 3'd6)) begin
          it.kind = fcs_pkg::BK_READ;
          it.addr = j.addr;
          it.word = '0;
          it.last = 1'b1;
        end
      end
      fcs_pkg::JOB_READ: begin
        it.kind = fcs_pkg::BK_READ;
        it.addr = j.addr;
        it.last = 1'b1;
      end
      fcs_pkg::JOB_FINISH: begin
        if (pos == 3'd2) begin
          it.kind   = fcs_pkg::BK_DONE;
          it.status = j.status;
          it.last   = 1'b1;
        end else begin
          it.addr = j.addr;
          it.word = fcs_pkg::CMD_RESET;
        end
      end
      fcs_pkg::JOB_ID_END: begin
        if (pos == 3'd1) begin
          it.kind = fcs_pkg::BK_DONE;
          it.id   = j.id;
          it.last = 1'b1;
        end else begin
          it.word = j.word;
        end
      end
      default: begin
        it.kind   = fcs_pkg::BK_DONE;
        it.status = j.status;
        it.id     = j.id;
        it.last   = 1'b1;
      end
    endcase
    return it;
  endfunction

  logic [2:0] step;
  logic       load;
  item_t      cur;

  assign cur  = item_of(job, step);
  assign load = !qstat.empty && (!bus.valid || bus.ready);
  assign pop  = load && cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus.valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        bus.valid <= 1'b1;
        step      <= cur.last ? 3'd0 : step + 3'd1;
      end else if (bus.ready) begin
        bus.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bus.bus_kind      <= cur.kind;
      bus.bus_address   <= cur.addr;
      bus.bus_word      <= cur.word;
      bus.result_status <= cur.status;
      bus.chip_id       <= cur.id;
      bus.last_of_run   <= cur.last;
    end
  end

endmodule
